FILE: rtl/core/rasr_pkg.sv
// ----------------------------------------------------------------------------
// rasr_pkg: shared types and constants for the rational add/sub/reduce block
// Operand width, derived widths, mode codes and the control struct.
// ----------------------------------------------------------------------------
package rasr_pkg;

    localparam int OPERAND_WIDTH = 16;
    // exact width of a sum of two operand products
    localparam int WIDE_W = 2 * OPERAND_WIDTH + 1;
    localparam int RES_W  = 32;
    localparam int CNT_W  = $clog2(WIDE_W + 1);

    localparam logic [1:0] MODE_ADD_RED = 2'd0;
    localparam logic [1:0] MODE_ADD_RAW = 2'd1;
    localparam logic [1:0] MODE_SUB_RAW = 2'd2;
    localparam logic [1:0] MODE_RED_A   = 2'd3;

    // status of the shared divider as seen by the sequencer
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctrl_t;

endpackage

FILE: rtl/core/rasr_if.sv
// ----------------------------------------------------------------------------
// rasr_in_if / rasr_out_if: valid/ready channels of the block
// Input word carries the mode and two fractions; output word the result.
// ----------------------------------------------------------------------------
interface rasr_in_if import rasr_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic [1:0]                      mode;
    logic signed [OPERAND_WIDTH-1:0] a_num;
    logic signed [OPERAND_WIDTH-1:0] a_den;
    logic signed [OPERAND_WIDTH-1:0] b_num;
    logic signed [OPERAND_WIDTH-1:0] b_den;
    modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rasr_out_if import rasr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    den_zero;
    modport source (output valid, res_num, res_den, den_zero, input ready);
    modport sink (input valid, res_num, res_den, den_zero, output ready);
endinterface

FILE: rtl/core/rasr_div.sv
// ----------------------------------------------------------------------------
// rasr_div: shared unsigned restoring divider
// One quotient bit per cycle; remainder and quotient held until next start.
// ----------------------------------------------------------------------------
module rasr_div import rasr_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [WIDE_W-1:0] divisor,
    output div_ctrl_t         stat,
    output logic [WIDE_W-1:0] quot,
    output logic [WIDE_W-1:0] rem
);

    logic [WIDE_W-1:0] q_reg, q_next, r_reg, r_next, d_reg, d_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [WIDE_W:0]   trial;

    // load on start, else one shift-subtract step while busy
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg, q_reg[WIDE_W-1]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = CNT_W'(WIDE_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                trial  = trial - {1'b0, d_reg};
                q_next = {q_reg[WIDE_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[WIDE_W-2:0], 1'b0};
            end
            r_next   = trial[WIDE_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign stat = '{start: start, busy: busy_reg, done: done_reg};
    assign quot = q_reg;
    assign rem  = r_reg;

    // done only ever follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg))
        else $error("divider done without busy");
    // a running count is never zero
    assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");
    // start is never issued while busy
    assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_reg)
        else $error("divider restarted while busy");

endmodule

FILE: rtl/core/rational_add_sub_reduce.sv
// ----------------------------------------------------------------------------
// rational_add_sub_reduce: signed fraction add/sub with gcd reduction
// Sequencer around one shared multiplier and one shared bit-serial divider.
// ----------------------------------------------------------------------------
// One word at a time. Raw modes form three products through one multiplier.
// Reducing modes run Euclid's gcd on the shared divider, one remainder per
// pass, then two more divisions for numerator and denominator.
// The input is not ready while a word is in work; the result sits in an
// output register until taken.
module rational_add_sub_reduce import rasr_pkg::*; (
    input logic        clk,
    input logic        rst_n,
    rasr_in_if.sink    in_ch,
    rasr_out_if.source out_ch
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_CHK  = 8'b0000_0100,
        S_GCD  = 8'b0000_1000,
        S_DVN  = 8'b0001_0000,
        S_DVD  = 8'b0010_0000,
        S_FIN  = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } state_t;

    localparam int PW = 2 * OPERAND_WIDTH;

    state_t state_reg, state_next;
    logic [1:0] mode_reg;
    logic signed [OPERAND_WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0] step_reg, step_next;
    logic signed [WIDE_W-1:0] n_reg, n_next, d_reg, d_next, p_reg;
    logic [WIDE_W-1:0] x_reg, x_next, y_reg, y_next;
    logic [WIDE_W-1:0] qn_reg, qn_next;
    logic signed [OPERAND_WIDTH-1:0] m_a, m_b;
    logic signed [PW-1:0] prod;
    logic div_start;
    logic [WIDE_W-1:0] div_a, div_b, quot, rem, mag_n, mag_d;
    div_ctrl_t dstat;
    logic go_reg, go_next;
    logic signed [RES_W-1:0] on_reg, od_reg;
    logic oz_reg, ov_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (step_reg)
            2'd0:    begin m_a = an_reg; m_b = bd_reg; end
            2'd1:    begin m_a = bn_reg; m_b = ad_reg; end
            default: begin m_a = ad_reg; m_b = bd_reg; end
        endcase
    end
    assign prod = m_a * m_b;

    assign mag_n = n_reg[WIDE_W-1] ? WIDE_W'(-n_reg) : WIDE_W'(n_reg);
    assign mag_d = d_reg[WIDE_W-1] ? WIDE_W'(-d_reg) : WIDE_W'(d_reg);

    rasr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .stat     (dstat),
        .quot     (quot),
        .rem      (rem)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        qn_next    = qn_reg;
        go_next    = 1'b0;
        div_start  = go_reg;
        div_a      = x_reg;
        div_b      = y_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    step_next  = 2'd0;
                    state_next = (in_ch.mode == MODE_RED_A) ? S_CHK : S_MUL;
                    n_next     = WIDE_W'(in_ch.a_num);
                    d_next     = WIDE_W'(in_ch.a_den);
                end
            end
            S_MUL:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd1)
                begin
                    n_next = (mode_reg == MODE_SUB_RAW) ? p_reg - WIDE_W'(prod)
                                                        : p_reg + WIDE_W'(prod);
                end
                else if (step_reg == 2'd2)
                begin
                    d_next     = WIDE_W'(prod);
                    state_next = (mode_reg == MODE_ADD_RED) ? S_CHK : S_FIN;
                end
            end
            S_CHK:
            begin
                if (n_reg == '0)
                begin
                    d_next     = WIDE_W'(1);
                    state_next = S_FIN;
                end
                else if (d_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    x_next     = mag_n;
                    y_next     = mag_d;
                    go_next    = 1'b1;
                    state_next = S_GCD;
                end
            end
            S_GCD:
            begin
                if (dstat.done)
                begin
                    if (rem == '0)
                    begin
                        x_next     = mag_n;
                        y_next     = y_reg;
                        go_next    = 1'b1;
                        state_next = S_DVN;
                    end
                    else
                    begin
                        x_next  = y_reg;
                        y_next  = rem;
                        go_next = 1'b1;
                    end
                end
            end
            S_DVN:
            begin
                if (dstat.done)
                begin
                    qn_next    = quot;
                    x_next     = mag_d;
                    go_next    = 1'b1;
                    state_next = S_DVD;
                end
            end
            S_DVD:
            begin
                if (dstat.done)
                begin
                    // sign goes to numerator, denominator positive
                    n_next = (n_reg[WIDE_W-1] ^ d_reg[WIDE_W-1]) ? -$signed(qn_reg)
                                                                : $signed(qn_reg);
                    d_next     = $signed(quot);
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ch.ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ch.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= go_next;
            if (state_reg == S_OUT && (!ov_reg || out_ch.ready))
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        qn_reg   <= qn_next;
        if (state_reg == S_MUL && step_reg == 2'd0)
        begin
            p_reg <= WIDE_W'(prod);
        end
        if (in_ch.valid && in_ch.ready)
        begin
            mode_reg <= in_ch.mode;
            an_reg   <= in_ch.a_num;
            ad_reg   <= in_ch.a_den;
            bn_reg   <= in_ch.b_num;
            bd_reg   <= in_ch.b_den;
        end
        if (state_reg == S_OUT && (!ov_reg || out_ch.ready))
        begin
            on_reg <= n_reg[RES_W-1:0];
            od_reg <= d_reg[RES_W-1:0];
            oz_reg <= (d_reg == '0);
        end
    end

    assign out_ch.valid    = ov_reg;
    assign out_ch.res_num  = on_reg;
    assign out_ch.res_den  = od_reg;
    assign out_ch.den_zero = oz_reg;

    // the gcd found divides the denominator magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DVD && dstat.done) |-> rem == '0)
        else $error("gcd does not divide denominator");
    // divider is only running in divider states
    assert property (@(posedge clk) disable iff (!rst_n)
        dstat.busy |-> (state_reg == S_GCD || state_reg == S_DVN || state_reg == S_DVD))
        else $error("divider busy outside division states");
    // a taken word always moves the sequencer out of idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> state_reg != S_IDLE)
        else $error("accepted word left sequencer idle");
    // divisor of every issued division is never zero
    assert property (@(posedge clk) disable iff (!rst_n)
        go_reg |-> y_reg != '0)
        else $error("division by zero issued");

endmodule

FILE: tb/sv/rasr_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rasr_tb_pkg: word types shared by the rational add/sub/reduce test
// Holds the input and result word layouts used by stimulus and checking.
// ----------------------------------------------------------------------------
package rasr_tb_pkg;
    import rasr_pkg::*;

    typedef struct {
        logic [1:0]                      mode;
        logic signed [OPERAND_WIDTH-1:0] a_num;
        logic signed [OPERAND_WIDTH-1:0] a_den;
        logic signed [OPERAND_WIDTH-1:0] b_num;
        logic signed [OPERAND_WIDTH-1:0] b_den;
    } frac_word_t;

    typedef struct {
        logic signed [RES_W-1:0] res_num;
        logic signed [RES_W-1:0] res_den;
        logic                    den_zero;
    } ratio_word_t;

endpackage

FILE: tb/sv/rational_add_sub_reduce_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_add_sub_reduce_test: self-checking test of the fraction unit
// Drives a directed table, then random words in bursts, and compares every
// result word against a typed-in result or a behavioral predictor of add, subtract and reduce.
// ----------------------------------------------------------------------------
module rational_add_sub_reduce_test;
    import rasr_pkg::*;
    import rasr_tb_pkg::*;

    localparam int N_RANDOM    = 1900;
    localparam int CYCLE_LIMIT = 12000000;
    localparam int N_TABLE     = 20;

    logic clk;
    logic rst_n;
    int   cycle_count;
    int   error_count;
    bit   stim_done;
    bit   hold_off;

    rasr_in_if  in_ch ();
    rasr_out_if out_ch ();

    rational_add_sub_reduce dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // directed stimulus; known marks a row whose result is typed in
    typedef struct {
        frac_word_t  word;
        bit          known;
        ratio_word_t result;
    } table_row_t;

    table_row_t  stim_table[N_TABLE];
    ratio_word_t pending_results[$];

    // magnitude of a wide signed value
    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // expected result of one fraction word
    function automatic ratio_word_t predict_ratio(frac_word_t w);
        ratio_word_t     r;
        longint          an;
        longint          ad;
        longint          bn;
        longint          bd;
        longint          n;
        longint          d;
        longint unsigned g;
        an = w.a_num;
        ad = w.a_den;
        bn = w.b_num;
        bd = w.b_den;
        if (w.mode == MODE_RED_A)
        begin
            n = an;
            d = ad;
        end
        else
        begin
            n = (w.mode == MODE_SUB_RAW) ? an * bd - bn * ad : an * bd + bn * ad;
            d = ad * bd;
        end
        if (w.mode == MODE_RED_A || w.mode == MODE_ADD_RED)
        begin
            if (n == 0)
                d = 1;
            else if (d != 0)
            begin
                g = euclid_gcd(magnitude(n), magnitude(d));
                n = n / longint'(g);
                d = d / longint'(g);
                if (d < 0)
                begin
                    d = -d;
                    n = -n;
                end
            end
        end
        r.res_num  = n[RES_W-1:0];
        r.res_den  = d[RES_W-1:0];
        r.den_zero = (d == 0);
        return r;
    endfunction

    function automatic frac_word_t make_word(logic [1:0] m, int an, int ad, int bn, int bd);
        frac_word_t w;
        w.mode  = m;
        w.a_num = an[OPERAND_WIDTH-1:0];
        w.a_den = ad[OPERAND_WIDTH-1:0];
        w.b_num = bn[OPERAND_WIDTH-1:0];
        w.b_den = bd[OPERAND_WIDTH-1:0];
        return w;
    endfunction

    function automatic ratio_word_t make_ratio(int n, int d, bit z);
        ratio_word_t r;
        r.res_num  = n;
        r.res_den  = d;
        r.den_zero = z;
        return r;
    endfunction

    // mostly small operands, sometimes full range, sometimes zero
    function automatic int rand_operand();
        int v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1, 2, 3: v = $urandom_range(0, 65535) - 32768;
            4:       v = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
            default: v = $urandom_range(0, 200) - 100;
        endcase
        return v;
    endfunction

    function automatic frac_word_t rand_word();
        int k;
        k = $urandom_range(1, 12);
        return make_word(2'($urandom_range(0, 3)), rand_operand() * k, rand_operand() * k,
                         rand_operand(), rand_operand());
    endfunction

    task automatic send_word(frac_word_t w);
        in_ch.valid <= 1'b1;
        in_ch.mode  <= w.mode;
        in_ch.a_num <= w.a_num;
        in_ch.a_den <= w.a_den;
        in_ch.b_num <= w.b_num;
        in_ch.b_den <= w.b_den;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    task automatic offer(frac_word_t w, bit known, ratio_word_t r);
        send_word(w);
        if (known)
            pending_results.push_back(r);
        else
            pending_results.push_back(predict_ratio(w));
        // random gap between bursts
        if ($urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
        forever
            #2 clk = ~clk;
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ch.ready <= 1'b0;
            else if (cycle_count % 512 < 128)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(0, 2) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        ratio_word_t exp_r;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word %0d/%0d", out_ch.res_num, out_ch.res_den);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (out_ch.res_num !== exp_r.res_num)
                begin
                    $error("res_num expected %0d got %0d", exp_r.res_num, out_ch.res_num);
                    error_count++;
                end
                if (out_ch.res_den !== exp_r.res_den)
                begin
                    $error("res_den expected %0d got %0d", exp_r.res_den, out_ch.res_den);
                    error_count++;
                end
                if (out_ch.den_zero !== exp_r.den_zero)
                begin
                    $error("den_zero expected %0b got %0b", exp_r.den_zero, out_ch.den_zero);
                    error_count++;
                end
            end
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        hold_off = 1'b0;
        wait (stim_done || cycle_count > 20000);
        if (!stim_done)
        begin
            hold_off = 1'b1;
            repeat (3000)
                @(posedge clk);
            hold_off = 1'b0;
        end
    end

    // stimulus
    initial
    begin
        ratio_word_t none;
        int          wait_cycles;
        none = make_ratio(0, 0, 1'b0);
        cycle_count = 0;
        error_count = 0;
        stim_done   = 1'b0;
        rst_n       = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.mode  = MODE_ADD_RED;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;

        stim_table[0]  = '{make_word(MODE_ADD_RED, 1, 2, 1, 3), 1'b1, make_ratio(5, 6, 1'b0)};
        stim_table[1]  = '{make_word(MODE_ADD_RAW, 1, 2, 1, 3), 1'b1, make_ratio(5, 6, 1'b0)};
        stim_table[2]  = '{make_word(MODE_SUB_RAW, 1, 2, 1, 3), 1'b1, make_ratio(1, 6, 1'b0)};
        stim_table[3]  = '{make_word(MODE_RED_A, 4, -8, 7, 9), 1'b1, make_ratio(-1, 2, 1'b0)};
        // zero over zero reduces to zero over one
        stim_table[4]  = '{make_word(MODE_RED_A, 0, 0, 0, 0), 1'b1, make_ratio(0, 1, 1'b0)};
        // zero denominator passes through with the flag
        stim_table[5]  = '{make_word(MODE_RED_A, 6, 0, 1, 1), 1'b1, make_ratio(6, 0, 1'b1)};
        stim_table[6]  = '{make_word(MODE_ADD_RAW, 3, 0, 1, 5), 1'b1, make_ratio(15, 0, 1'b1)};
        stim_table[7]  = '{make_word(MODE_ADD_RED, 3, 0, 1, 5), 1'b1, make_ratio(15, 0, 1'b1)};
        // numerator wraps to the most negative value
        stim_table[8]  = '{make_word(MODE_ADD_RAW, -32768, -32768, -32768, -32768), 1'b1,
                           make_ratio(32'h8000_0000, 32'h4000_0000, 1'b0)};
        stim_table[9]  = '{make_word(MODE_ADD_RED, -32768, -32768, -32768, -32768), 1'b1,
                           make_ratio(2, 1, 1'b0)};
        stim_table[10] = '{make_word(MODE_SUB_RAW, 32767, -32768, -32768, 32767), 0, none};
        stim_table[11] = '{make_word(MODE_ADD_RED, 32767, 32767, 32767, 32767), 0, none};
        stim_table[12] = '{make_word(MODE_ADD_RED, -32768, 32767, 32767, -32768), 0, none};
        stim_table[13] = '{make_word(MODE_SUB_RAW, -1, -1, -1, -1), 1'b1,
                           make_ratio(0, 1, 1'b0)};
        stim_table[14] = '{make_word(MODE_RED_A, -32768, 32767, 0, 0), 0, none};
        stim_table[15] = '{make_word(MODE_RED_A, 12, -18, -32768, 32767), 0, none};
        stim_table[16] = '{make_word(MODE_ADD_RED, 1, 3, -1, 3), 1'b1, make_ratio(0, 1, 1'b0)};
        stim_table[17] = '{make_word(MODE_ADD_RED, -32768, 1, 32767, 1), 0, none};
        stim_table[18] = '{make_word(MODE_SUB_RAW, 0, 0, 5, 7), 1'b1, make_ratio(0, 0, 1'b1)};
        stim_table[19] = '{make_word(MODE_ADD_RED, 21845, -10922, -21846, 10923), 0, none};

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < N_TABLE; i++)
            offer(stim_table[i].word, stim_table[i].known, stim_table[i].result);

        // random words
        for (int i = 0; i < N_RANDOM; i++)
            offer(rand_word(), 1'b0, none);
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;

        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (500)
            @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rasr_pkg.sv
rtl/core/rasr_if.sv
rtl/core/rasr_div.sv
rtl/core/rational_add_sub_reduce.sv
tb/sv/rasr_tb_pkg.sv
tb/sv/rational_add_sub_reduce_test.sv
